// ===== hdl/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: register map, reset values,
// phase and sequencer encodings, configuration struct. No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

  localparam int COUNTER_BITS_DEF = 17;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int TRIG_W = 10;
  localparam int TMO_W  = 17;
  localparam int DIV_W  = 8;
  localparam int CM_W   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CM_DIVISOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CM        = 3'd4;

  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 10'd10;
  localparam logic [TMO_W-1:0]  TIMEOUT_TICKS_RST = 17'd70000;
  localparam logic [DIV_W-1:0]  CM_DIVISOR_RST    = 8'd59;
  localparam logic [CM_W-1:0]   MIN_CM_RST        = 10'd2;
  localparam logic [CM_W-1:0]   MAX_CM_RST        = 10'd400;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_t;

  typedef enum logic {
    SQ_TICK = 1'b0,
    SQ_DIV  = 1'b1
  } seq_t;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_ticks;
    logic [TMO_W-1:0]  timeout_ticks;
    logic [DIV_W-1:0]  cm_divisor;
    logic [CM_W-1:0]   min_cm;
    logic [CM_W-1:0]   max_cm;
  } cfg_t;

endpackage

// ===== hdl/uer_regs.sv =====
// Configuration register file of the echo ranger: five write-only registers.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_regs
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks <= TRIGGER_TICKS_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg.cm_divisor    <= CM_DIVISOR_RST;
      cfg.min_cm        <= MIN_CM_RST;
      cfg.max_cm        <= MAX_CM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_TICKS: cfg.trigger_ticks <= cfg_data[TRIG_W-1:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[TMO_W-1:0];
        REG_CM_DIVISOR:    cfg.cm_divisor    <= cfg_data[DIV_W-1:0];
        REG_MIN_CM:        cfg.min_cm        <= cfg_data[CM_W-1:0];
        REG_MAX_CM:        cfg.max_cm        <= cfg_data[CM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/uer_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_div
  import uer_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [COUNTER_BITS-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    done,
  output logic [COUNTER_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(COUNTER_BITS);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [COUNTER_BITS-1:0] work;
  logic [DIV_W-1:0]        rem;
  logic [DIV_W-1:0]        dvs;
  logic [DIV_W:0]          rem_sh;
  logic [DIV_W:0]          rem_sub;
  logic                    qbit;

  assign rem_sh  = {rem, work[COUNTER_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign qbit    = (rem_sh >= {1'b0, dvs});
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(COUNTER_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[COUNTER_BITS-2:0], qbit};
      rem  <= qbit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

endmodule

// ===== hdl/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger top level: tick sequencer, output register.
// Depends on uer_pkg, uer_regs, uer_div.
//
// Usage: each input word is one microsecond tick carrying start_req and the
// sampled echo_level (valid/ready). Each accepted tick yields exactly one
// output word (valid/ready) with trigger_level, done_res, distance_cm and
// timed_out. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); writes to unknown indexes are dropped.
// Flow: an ordinary tick's word appears the cycle after acceptance, one
// word per cycle while the receiver keeps up and no division runs. The tick
// on which the echo falls starts the restoring divider, one quotient bit a
// cycle: that word is loaded into the output register when the divider
// reports done, and no tick is taken meanwhile.
// The output register frees on the cycle it is read, so a new tick is taken
// while a finished word is being taken; if the receiver stalls, in_ready
// drops until the held word goes.
// Reset (rst, synchronous) loads the register defaults, returns to idle and
// empties the output register.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  start_req,
  input  logic                  echo_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  trigger_level,
  output logic                  done_res,
  output logic [CM_W-1:0]       distance_cm,
  output logic                  timed_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CMP_W = (COUNTER_BITS > TMO_W) ? COUNTER_BITS : TMO_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  cfg_t cfg;

  phase_t                  phase, phase_next;
  seq_t                    seq, seq_next;
  logic [COUNTER_BITS-1:0] window_count, window_count_next;
  logic [COUNTER_BITS-1:0] echo_width, echo_width_next;
  logic [COUNTER_BITS-1:0] wc_inc, ew_inc;
  logic [TRIG_W-1:0]       trig_len;
  logic [DIV_W-1:0]        div_eff;
  logic                    accept;
  logic                    div_start, div_done;
  logic [COUNTER_BITS-1:0] quotient;
  logic                    load;
  logic                    o_trig, o_done, o_tmo;
  logic [CM_W-1:0]         o_dist;
  logic                    in_range;

  uer_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_div #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (echo_width),
    .divisor  (div_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_ready = (seq == SQ_TICK) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign trig_len = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;
  assign div_eff  = (cfg.cm_divisor == '0) ? DIV_W'(1) : cfg.cm_divisor;
  assign wc_inc   = (window_count == CNT_MAX) ? window_count : window_count + 1'b1;
  assign ew_inc   = (echo_width == CNT_MAX) ? echo_width : echo_width + 1'b1;
  assign in_range = (quotient <= COUNTER_BITS'(cfg.max_cm)) &&
                    (quotient >= COUNTER_BITS'(cfg.min_cm));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      seq          <= SQ_TICK;
      window_count <= '0;
      echo_width   <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      seq          <= seq_next;
      window_count <= window_count_next;
      echo_width   <= echo_width_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trigger_level <= o_trig;
      done_res      <= o_done;
      distance_cm   <= o_dist;
      timed_out     <= o_tmo;
    end
  end

  always_comb begin
    phase_next        = phase;
    seq_next          = seq;
    window_count_next = window_count;
    echo_width_next   = echo_width;
    div_start         = 1'b0;
    load              = 1'b0;
    o_trig            = 1'b0;
    o_done            = 1'b0;
    o_tmo             = 1'b0;
    o_dist            = '0;
    case (seq)
      SQ_TICK: begin
        if (accept) begin
          load = 1'b1;
          case (phase)
            PH_IDLE: begin
              if (start_req) begin
                o_trig          = 1'b1;
                echo_width_next = '0;
                if (trig_len <= TRIG_W'(1)) begin
                  phase_next        = PH_WAIT;
                  window_count_next = '0;
                end else begin
                  phase_next        = PH_TRIG;
                  window_count_next = COUNTER_BITS'(1);
                end
              end
            end
            PH_TRIG: begin
              o_trig            = 1'b1;
              window_count_next = wc_inc;
              if ((wc_inc >= COUNTER_BITS'(trig_len)) || (wc_inc == CNT_MAX)) begin
                phase_next        = PH_WAIT;
                window_count_next = '0;
              end
            end
            default: begin
              if (phase == PH_MEAS && !echo_level) begin
                // falling echo: result comes from the divider
                load       = 1'b0;
                div_start  = 1'b1;
                seq_next   = SQ_DIV;
                phase_next = PH_IDLE;
              end else begin
                if (echo_level) begin
                  echo_width_next = (phase == PH_WAIT) ? COUNTER_BITS'(1) : ew_inc;
                  phase_next      = PH_MEAS;
                end
                window_count_next = wc_inc;
                if ((CMP_W'(wc_inc) >= CMP_W'(cfg.timeout_ticks)) ||
                    (wc_inc == CNT_MAX)) begin
                  o_done     = 1'b1;
                  o_tmo      = 1'b1;
                  o_dist     = cfg.max_cm;
                  phase_next = PH_IDLE;
                end
              end
            end
          endcase
        end
      end
      SQ_DIV: begin
        if (div_done) begin
          load     = 1'b1;
          o_done   = 1'b1;
          o_dist   = in_range ? quotient[CM_W-1:0] : cfg.max_cm;
          seq_next = SQ_TICK;
        end
      end
      default: seq_next = SQ_TICK;
    endcase
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for ultrasonic_echo_ranger: ticks go in through a queued
// driver, every output word is checked against an in-bench range predictor.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
`timescale 1ns / 1ps

module tb;
  import uer_pkg::*;

  localparam int CNT_W        = COUNTER_BITS_DEF;
  localparam int DRAIN_CYCLES = CNT_W + 12;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic start;
    logic echo;
  } tick_t;

  typedef struct packed {
    logic            trig;
    logic            done;
    logic [CM_W-1:0] dist_cm;
    logic            tmo;
  } range_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  start_req = 1'b0;
  logic                  echo_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  trigger_level;
  logic                  done_res;
  logic [CM_W-1:0]       distance_cm;
  logic                  timed_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ultrasonic_echo_ranger dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_req    (start_req),
    .echo_level   (echo_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .trigger_level(trigger_level),
    .done_res     (done_res),
    .distance_cm  (distance_cm),
    .timed_out    (timed_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // range predictor state
  cfg_t ranger_cfg = '{
    trigger_ticks: TRIGGER_TICKS_RST,
    timeout_ticks: TIMEOUT_TICKS_RST,
    cm_divisor:    CM_DIVISOR_RST,
    min_cm:        MIN_CM_RST,
    max_cm:        MAX_CM_RST
  };
  phase_t           ranger_phase = PH_IDLE;
  logic [CNT_W-1:0] window_cnt = '0;
  logic [CNT_W-1:0] echo_ticks = '0;

  tick_t       ticks_to_send[$];
  range_word_t ranger_words_due[$];

  int unsigned queued_ticks = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [CM_W-1:0] echo_to_cm(input logic [CNT_W-1:0] width);
    logic [CNT_W-1:0] div;
    logic [CNT_W-1:0] q;
    div = (ranger_cfg.cm_divisor == '0) ? CNT_W'(1) : CNT_W'(ranger_cfg.cm_divisor);
    q = width / div;
    if (q > ranger_cfg.max_cm || q < ranger_cfg.min_cm) return ranger_cfg.max_cm;
    return q[CM_W-1:0];
  endfunction

  // advances the predictor by one tick and returns the word it must produce
  function automatic range_word_t ranger_tick(input logic start, input logic echo);
    range_word_t w;
    int unsigned trig_len;
    w = '0;
    trig_len = (ranger_cfg.trigger_ticks == '0) ? 1 : ranger_cfg.trigger_ticks;
    case (ranger_phase)
      PH_IDLE: begin
        if (start) begin
          w.trig = 1'b1;
          echo_ticks = '0;
          if (trig_len <= 1) begin
            ranger_phase = PH_WAIT;
            window_cnt = '0;
          end else begin
            ranger_phase = PH_TRIG;
            window_cnt = CNT_W'(1);
          end
        end
      end
      PH_TRIG: begin
        w.trig = 1'b1;
        window_cnt = sat_inc(window_cnt);
        if (window_cnt >= trig_len || window_cnt == '1) begin
          ranger_phase = PH_WAIT;
          window_cnt = '0;
        end
      end
      default: begin
        if (ranger_phase == PH_MEAS && !echo) begin
          w.done = 1'b1;
          w.dist_cm = echo_to_cm(echo_ticks);
          ranger_phase = PH_IDLE;
        end else begin
          if (echo) begin
            echo_ticks = (ranger_phase == PH_WAIT) ? CNT_W'(1) : sat_inc(echo_ticks);
            ranger_phase = PH_MEAS;
          end
          window_cnt = sat_inc(window_cnt);
          if (window_cnt >= ranger_cfg.timeout_ticks || window_cnt == '1) begin
            w.done = 1'b1;
            w.tmo = 1'b1;
            w.dist_cm = ranger_cfg.max_cm;
            ranger_phase = PH_IDLE;
          end
        end
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTS)
      $display("%0t %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_word();
    range_word_t want;
    if (ranger_words_due.size() == 0) begin
      report_mismatch("word with nothing due", distance_cm, 0);
    end else begin
      want = ranger_words_due.pop_front();
      if (trigger_level !== want.trig) report_mismatch("trigger_level", trigger_level, want.trig);
      if (done_res !== want.done) report_mismatch("done_res", done_res, want.done);
      if (distance_cm !== want.dist_cm) report_mismatch("distance_cm", distance_cm, want.dist_cm);
      if (timed_out !== want.tmo) report_mismatch("timed_out", timed_out, want.tmo);
    end
  endtask

  // tick driver
  always @(posedge clk) begin
    tick_t t;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) ranger_words_due.push_back(ranger_tick(start_req, echo_level));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (ticks_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          t = ticks_to_send.pop_front();
          start_req <= t.start;
          echo_level <= t.echo;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) check_word();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && ticks_to_send.size() == 0 && ranger_words_due.size() == 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ultrasonic_echo_ranger: mismatch");
        $finish;
      end
    end
  end

  function automatic logic busy_start();
    return $urandom_range(0, 7) == 0;
  endfunction

  task automatic add_tick(input logic start, input logic echo);
    ticks_to_send.push_back('{start: start, echo: echo});
    queued_ticks++;
  endtask

  // start, trigger, wait for rise, echo high, then the falling tick
  task automatic add_measurement(input int unsigned rise_delay, input int unsigned high_len);
    int unsigned trig_len;
    trig_len = (ranger_cfg.trigger_ticks == '0) ? 1 : ranger_cfg.trigger_ticks;
    add_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (trig_len - 1) add_tick(busy_start(), 1'($urandom_range(0, 1)));
    repeat (rise_delay) add_tick(busy_start(), 1'b0);
    repeat (high_len) add_tick(busy_start(), 1'b1);
    add_tick(busy_start(), 1'b0);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (ticks_to_send.size() != 0 || in_valid || ranger_words_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TRIGGER_TICKS: ranger_cfg.trigger_ticks = data[TRIG_W-1:0];
      REG_TIMEOUT_TICKS: ranger_cfg.timeout_ticks = data[TMO_W-1:0];
      REG_CM_DIVISOR:    ranger_cfg.cm_divisor = data[DIV_W-1:0];
      REG_MIN_CM:        ranger_cfg.min_cm = data[CM_W-1:0];
      REG_MAX_CM:        ranger_cfg.max_cm = data[CM_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise; sometimes an unmapped index is hit too
  task automatic set_ranging(input int unsigned trig, input int unsigned tmo,
                             input int unsigned div, input int unsigned mn,
                             input int unsigned mx);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[TRIG_W-1:0] = TRIG_W'(trig);
    write_reg(REG_TRIGGER_TICKS, d);
    write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
    d = CFG_DATA_W'($urandom);
    d[DIV_W-1:0] = DIV_W'(div);
    write_reg(REG_CM_DIVISOR, d);
    d = CFG_DATA_W'($urandom);
    d[CM_W-1:0] = CM_W'(mn);
    write_reg(REG_MIN_CM, d);
    d = CFG_DATA_W'($urandom);
    d[CM_W-1:0] = CM_W'(mx);
    write_reg(REG_MAX_CM, d);
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_IDX_W'(REG_MAX_CM + 1 + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
  endtask

  task automatic add_random_traffic(input int unsigned n_ticks);
    int unsigned first;
    int unsigned div_eff;
    int unsigned tmo_span;
    int unsigned cm;
    int unsigned width;
    first = queued_ticks;
    div_eff = (ranger_cfg.cm_divisor == '0) ? 1 : ranger_cfg.cm_divisor;
    tmo_span = (ranger_cfg.timeout_ticks > 300) ? 300 : ranger_cfg.timeout_ticks + 2;
    while (queued_ticks - first < n_ticks) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 16))
             add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1: add_measurement($urandom_range(0, tmo_span), $urandom_range(0, tmo_span));
        default: begin
          cm = $urandom_range(0, ranger_cfg.max_cm + 2);
          width = cm * div_eff + $urandom_range(0, div_eff - 1);
          if (width == 0 || width > 400) width = $urandom_range(1, 400);
          add_measurement($urandom_range(0, 3), width);
        end
      endcase
      repeat ($urandom_range(0, 3)) add_tick(1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned n_phases;
    n_phases = 10;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: echo seen in idle is ignored, rise on first waiting tick,
    // exactly min_cm and one cm below it
    idle_on = 1'b1;
    add_tick(1'b0, 1'b1);
    add_tick(1'b0, 1'b0);
    add_measurement(0, 118);
    add_measurement(3, 59);
    settle();

    // all zero: zero trigger, timeout and divisor; rise on the timeout tick,
    // request on the completing tick
    set_ranging(0, 0, 0, 0, 0);
    add_measurement(0, 1);
    add_tick(1'b1, 1'b0);
    add_tick(1'b1, 1'b1);
    add_measurement(0, 0);
    settle();

    set_ranging(1, 20, 0, 0, 1023);
    add_measurement(2, 7);
    settle();

    // fall on the timeout tick wins, late rise does not
    set_ranging(2, 4, 255, 1023, 1023);
    add_measurement(0, 3);
    add_measurement(3, 2);
    settle();

    // crossed limits
    set_ranging(2, 400, 1, 200, 100);
    add_measurement(1, 150);
    settle();

    // limit boundaries
    set_ranging(3, 400, 2, 5, 50);
    add_measurement(0, 102);
    add_measurement(1, 101);
    add_measurement(0, 9);
    add_measurement(2, 10);
    settle();

    for (int p = 0; p < n_phases; p++) begin
      idle_on = (p != n_phases - 1) && ($urandom_range(0, 3) != 0);
      set_ranging(
        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6),
        ($urandom_range(0, 6) == 0) ? $urandom_range(0, 12) : $urandom_range(40, 500),
        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5),
        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 10),
        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 60));
      add_random_traffic(70);
      settle();
    end

    if (mismatches == 0) begin
      $display("ultrasonic_echo_ranger: match");
    end else begin
      $display("ultrasonic_echo_ranger: mismatch");
    end
    $finish;
  end

endmodule
